/* hw/rtl/dasu_pkg.sv */
package dasu_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned MANT_W  = 53;
    localparam int unsigned GUARD_W = 32;
    localparam int unsigned EXP_W   = 11;

    localparam logic [WORD_W-1:0]  SIGN_BIT  = 64'h8000_0000_0000_0000;
    localparam logic [EXP_W-1:0]   EXP_MAX   = 11'h7ff;
    localparam logic [GUARD_W-1:0] GUARD_TOP = 32'h8000_0000;
    localparam int                 FAR_APART = 54;

    // Aligned mantissa plus guard word
    typedef struct packed {
        logic [MANT_W-1:0]  mant;
        logic [GUARD_W-1:0] guard;
    } t_align;

    // Right shift by 1..54. Above 32 the whole low word only feeds guard bit 0.
    function automatic t_align align_right(input logic [MANT_W-1:0] m,
                                           input logic [5:0] s);
        t_align                     res;
        logic [MANT_W+GUARD_W-1:0]  wide;
        logic [20:0]                hi;
        logic [31:0]                lo;
        logic [63:0]                hw;
        logic [5:0]                 s2;
        hi   = m[52:32];
        lo   = m[31:0];
        s2   = s - 6'd32;
        wide = {m, {GUARD_W{1'b0}}} >> s;
        hw   = {11'd0, hi, 32'd0} >> s2;
        if (s > 6'd32) begin
            res.mant  = {32'd0, hi >> s2};
            res.guard = hw[31:0] | {31'd0, (lo != 32'd0)};
        end else begin
            res.mant  = wide[MANT_W+GUARD_W-1:GUARD_W];
            res.guard = wide[GUARD_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/double_add_subtract.sv */
// Double precision add/subtract, no denormals, round to nearest even.
// Slave channel: s_axis_tdata = {second, first} operand words, s_axis_tuser
// = command (0 add, 1 subtract). Master channel: m_axis_tdata = result word,
// m_axis_tuser = ok flag (0 on exponent overflow, data then zero).
// Each request passes an input register, one pass of align/add/normalize/
// round logic, and the result register, which drives m_axis_tvalid. One
// request per cycle is taken sustained; a stalled output holds the result
// register and backs up the input.
// A zero exponent or an exponent gap above 54 returns the other operand.
// Reset (synchronous, active low) empties both stages and drops requests in
// flight; s_axis_tready stays low while reset is held.
// When the receiver stalls, the result holds and the input stage still
// takes one more request; then s_axis_tready drops until the output moves.
module double_add_subtract (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // [63:0] first_operand, [127:64] second_operand
    input  logic [0:0]   s_axis_tuser,  // [0] command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // [63:0] sum_value
    output logic [0:0]   m_axis_tuser   // [0] ok_flag
);
    import dasu_pkg::*;

    logic              r_v1, r_v2;
    logic              r_cmd;
    logic [63:0]       r_a, r_b;
    logic [63:0]       r_res;
    logic              r_ok;
    logic              ld1, ld2;

    logic              sb, sc, is_diff, neg;
    logic [63:0]       x, y;
    logic [10:0]       xe, ye;
    logic signed [12:0] d, e;
    logic [5:0]        sh;
    t_align            ax, ay;
    logic [52:0]       mx, my, m;
    logic [31:0]       g, gd;
    logic [53:0]       ms, md, m1;
    logic              borrow, sgn, ru, done;
    logic [84:0]       v, vs;
    logic [6:0]        lz;
    logic [63:0]       n_res;
    logic              n_ok;

    // Stage handshake
    assign ld2           = r_v1 && (!r_v2 || m_axis_tready);
    assign ld1           = !r_v1 || ld2;
    assign s_axis_tready = i_rst_n && ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= s_axis_tvalid;
            if (ld2) r_v2 <= 1'b1;
            else if (m_axis_tready) r_v2 <= 1'b0;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (ld1 && s_axis_tvalid) begin
            r_cmd <= s_axis_tuser[0];
            r_a   <= s_axis_tdata[63:0];
            r_b   <= s_axis_tdata[127:64];
        end
    end

    // Align, add or subtract, normalize, round
    always_comb begin
        sb      = r_a[63];
        sc      = r_b[63] ^ r_cmd;
        is_diff = sb ^ sc;
        neg     = sb & sc;
        x       = (is_diff && sb) ? {1'b0, r_b[62:0]} : {1'b0, r_a[62:0]};
        y       = (is_diff && sb) ? {1'b0, r_a[62:0]} : {1'b0, r_b[62:0]};
        xe      = x[62:52];
        ye      = y[62:52];
        d       = $signed({2'b00, xe}) - $signed({2'b00, ye});
        sh      = (d < 0) ? 6'(-d) : 6'(d);
        ax      = align_right({1'b1, x[51:0]}, sh);
        ay      = align_right({1'b1, y[51:0]}, sh);
        mx      = {1'b1, x[51:0]};
        my      = {1'b1, y[51:0]};
        g       = '0;
        gd      = '0;
        e       = $signed({2'b00, xe});
        m       = '0;
        ms      = '0;
        md      = '0;
        m1      = '0;
        borrow  = 1'b0;
        sgn     = 1'b0;
        ru      = 1'b0;
        done    = 1'b0;
        v       = '0;
        vs      = '0;
        lz      = '0;
        n_res   = '0;
        n_ok    = 1'b1;

        if (d < -13'sd54 || xe == 11'd0) begin
            n_res = is_diff ? (y ^ SIGN_BIT) : y;
            done  = 1'b1;
        end else if (d > 13'sd54 || ye == 11'd0) begin
            n_res = x;
            done  = 1'b1;
        end else begin
            // Alignment of the smaller operand
            if (d > 0) begin
                my = ay.mant;
                gd = ay.guard;   // guard of y
            end else if (d < 0) begin
                mx = ax.mant;
                g  = ax.guard;   // guard of x
                e  = $signed({2'b00, ye});
            end
            if (!is_diff) begin
                g  = g | gd;
                ms = {1'b0, mx} + {1'b0, my};
                if (ms[53]) begin
                    g = {ms[0], g[31:1]};
                    m = ms[53:1];
                    e = e + 13'sd1;
                    if (e >= $signed({2'b00, EXP_MAX})) begin
                        n_ok = 1'b0;
                        done = 1'b1;
                    end
                end else begin
                    m = ms[52:0];
                end
            end else begin
                borrow = g < gd;
                g      = g - gd;
                md     = {1'b0, mx} - {1'b0, my} - {53'd0, borrow};
                if (md[53]) begin
                    if (g == 32'd0) md = -md;
                    else begin
                        g  = -g;
                        md = ~md;
                    end
                    sgn = 1'b1;
                end
                m = md[52:0];
                if (m == 53'd0 && g == 32'd0) begin
                    n_res = '0;
                    done  = 1'b1;
                end else if (!m[52]) begin
                    // Leading zero count over mantissa and guard
                    v = {m, g};
                    for (int i = 0; i < 85; i++) begin
                        if (v[i]) lz = 7'(84 - i);
                    end
                    vs = v << lz;
                    m  = vs[84:32];
                    g  = vs[31:0];
                    e  = e - $signed({6'd0, lz});
                    if (e <= 0) begin
                        n_res = '0;
                        done  = 1'b1;
                    end
                end
            end
            // Round to nearest even
            if (!done) begin
                ru = g[31] && (m[0] || g != GUARD_TOP);
                m1 = {1'b0, m} + {53'd0, ru};
                if (m1[53]) begin
                    e = e + 13'sd1;
                    if (e >= $signed({2'b00, EXP_MAX})) n_ok = 1'b0;
                end
                n_res = {sgn, e[10:0], m1[51:0]};
            end
        end
        if (neg) n_res = n_res ^ SIGN_BIT;
        if (!n_ok) n_res = '0;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_res <= n_res;
            r_ok  <= n_ok;
        end
    end

    assign m_axis_tvalid   = r_v2;
    assign m_axis_tdata    = r_res;
    assign m_axis_tuser[0] = r_ok;

endmodule

/* hw/rtl/dasu_checker.sv */
module dasu_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);
    import dasu_pkg::*;

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Overflow result carries zero data
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("overflow result not zero");

    // Input only blocks when the output is held
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without output stall");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A result of only the sign bit, the top of the word, carries the ok flag
    a_sign_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata == SIGN_BIT |-> m_axis_tuser[0])
        else $error("negative zero flagged as overflow");

endmodule

bind double_add_subtract dasu_checker u_dasu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
